### hdl/cft_pkg.sv
`timescale 1ns / 1ps

package cft_pkg;

	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_QUOTE = 8'h22;
	localparam logic [7:0] BYTE_SPACE = 8'h20;

	localparam logic [7:0] DELIM_RESET = 8'd44;

	// Space count saturates at the smaller of the nominal limit and the counter range
	localparam int unsigned MAX_PENDING_SPACES = 255;
	localparam logic [7:0]  SPACE_CAP = (MAX_PENDING_SPACES < 255) ?
		8'(MAX_PENDING_SPACES) : 8'd255;

	typedef enum logic [1:0] {
		KIND_CHAR       = 2'd0,
		KIND_FIELD_END  = 2'd1,
		KIND_RECORD_END = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] spaces;
		logic [7:0] ch;
	} res_t;

endpackage

### hdl/csv_field_tokenizer_unit.sv
`timescale 1ns / 1ps

// CSV field tokenizer. Takes one text byte per word on the slave side and
// gives at most one token word per byte on the master side: a field character
// (with the count of interior spaces that go before it), an end of field, or
// an end of field and record. Fields split at the delimiter register outside
// quoted runs, records at newline; the first carriage return of each line is
// dropped and spaces are trimmed at both field ends. A word with tlast set is
// an end-of-stream marker that closes an unterminated line. Throughput is one
// byte per clock while s_axis_tready is high: the parse state updates in the
// same cycle a byte is taken, and the token is registered into a two-word
// output buffer, which keeps s_axis_tready high while one token waits on the
// master side; tready drops only when both words are held.
// Write the delimiter (reset value ',') only while the stream is idle.

module csv_field_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,       // delimiter

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
	input  logic        s_axis_tlast,    // end_of_input

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,    // [7:0] char_out, [15:8] spaces_before
	output logic [1:0]  m_axis_tuser     // kind
);

	logic [7:0]    delimiter_q;
	logic          accept;
	logic          res_valid;
	cft_pkg::res_t res;
	cft_pkg::res_t out_res;
	logic          buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= cft_pkg::DELIM_RESET;
		end else if (cfg_we) begin
			delimiter_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = buf_ready;
	assign accept        = s_axis_tvalid && buf_ready;

	cft_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (s_axis_tdata),
		.end_of_input (s_axis_tlast),
		.delimiter    (delimiter_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	cft_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.can_accept (buf_ready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (out_res)
	);

	assign m_axis_tdata = {out_res.spaces, out_res.ch};
	assign m_axis_tuser = out_res.kind;

`ifndef SYNTHESIS
	// a held second word always sits behind a held first word
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		u_out_buf.skid_valid_q |-> m_axis_tvalid)
		else $error("output buffer: skid word without main word");

	// a token is always waiting on the master side in the cycle after a newline byte is taken
	a_newline_token: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_axis_tlast && s_axis_tdata == cft_pkg::BYTE_LF) |=> m_axis_tvalid)
		else $error("newline produced no record end");

	// end tokens carry no character and no space count
	a_end_token_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != cft_pkg::KIND_CHAR) |-> m_axis_tdata == 16'd0)
		else $error("end token with nonzero payload");

	// a stalled token stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser)))
		else $error("token changed while stalled");
`endif

endmodule

### hdl/cft_parse.sv
`timescale 1ns / 1ps

module cft_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              end_of_input,
	input  logic [7:0]        delimiter,
	output logic              res_valid,
	output cft_pkg::res_t     res
);

	logic       in_quotes_q, field_has_text_q, cr_dropped_q, line_has_bytes_q;
	logic [7:0] pending_q;

	logic       in_quotes_n, field_has_text_n, cr_dropped_n, line_has_bytes_n;
	logic [7:0] pending_n;
	logic       emit;

	always_comb begin
		in_quotes_n      = in_quotes_q;
		field_has_text_n = field_has_text_q;
		cr_dropped_n     = cr_dropped_q;
		line_has_bytes_n = line_has_bytes_q;
		pending_n        = pending_q;
		emit             = 1'b0;
		res              = '0;
		res.kind         = cft_pkg::KIND_CHAR;

		if (end_of_input || data_byte == cft_pkg::BYTE_LF) begin
			// record end; a bare end of stream on an empty line is silent
			if (!end_of_input || line_has_bytes_q) begin
				emit             = 1'b1;
				res.kind         = cft_pkg::KIND_RECORD_END;
				in_quotes_n      = 1'b0;
				field_has_text_n = 1'b0;
				cr_dropped_n     = 1'b0;
				line_has_bytes_n = 1'b0;
				pending_n        = '0;
			end
		end else begin
			line_has_bytes_n = 1'b1;
			if (data_byte == cft_pkg::BYTE_CR && !cr_dropped_q) begin
				cr_dropped_n = 1'b1;
			end else if (!in_quotes_q && data_byte != cft_pkg::BYTE_QUOTE &&
					data_byte == delimiter) begin
				emit             = 1'b1;
				res.kind         = cft_pkg::KIND_FIELD_END;
				field_has_text_n = 1'b0;
				pending_n        = '0;
			end else if (data_byte == cft_pkg::BYTE_SPACE) begin
				// leading spaces vanish, interior ones are counted
				if (field_has_text_q && pending_q < cft_pkg::SPACE_CAP)
					pending_n = pending_q + 8'd1;
			end else begin
				if (data_byte == cft_pkg::BYTE_QUOTE)
					in_quotes_n = !in_quotes_q;
				emit             = 1'b1;
				res.ch           = data_byte;
				res.spaces       = pending_q;
				pending_n        = '0;
				field_has_text_n = 1'b1;
			end
		end
	end

	assign res_valid = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q      <= 1'b0;
			field_has_text_q <= 1'b0;
			cr_dropped_q     <= 1'b0;
			line_has_bytes_q <= 1'b0;
			pending_q        <= '0;
		end else if (accept) begin
			in_quotes_q      <= in_quotes_n;
			field_has_text_q <= field_has_text_n;
			cr_dropped_q     <= cr_dropped_n;
			line_has_bytes_q <= line_has_bytes_n;
			pending_q        <= pending_n;
		end
	end

endmodule

### hdl/cft_out_buf.sv
`timescale 1ns / 1ps

module cft_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cft_pkg::res_t push_data,
	output logic          can_accept,
	output logic          out_valid,
	input  logic          out_ready,
	output cft_pkg::res_t out_data
);

	logic          main_valid_q, skid_valid_q;
	cft_pkg::res_t main_q, skid_q;
	logic          pop;

	assign pop        = main_valid_q && out_ready;
	assign can_accept = !skid_valid_q;
	assign out_valid  = main_valid_q;
	assign out_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_data;
		end else if (push) begin
			if (main_valid_q)
				skid_q <= push_data;
			else
				main_q <= push_data;
		end
	end

endmodule
